// ===== hdl/hbs_pkg.sv =====
package hbs_pkg;

  localparam int MaxWidth    = 4096;
  localparam int MaxChannels = 4;
  localparam int SampleBits  = 16;
  localparam int AddrBits    = $clog2(MaxWidth);
  localparam int LaneBits    = SampleBits + 2;
  localparam int SumBits     = SampleBits + 4;
  localparam int NumBits     = 27;
  localparam int FifoDepth   = 4;
  localparam int FifoPtrBits = $clog2(FifoDepth);

  // Reciprocal of 450 scaled by 2**36, exact for 27-bit numerators.
  localparam int          RecipShift = 36;
  localparam logic [27:0] Recip450   = 28'd152709949;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_CHANNEL = 3'd2,
    REG_DEPTH   = 3'd3,
    REG_PERCENT = 3'd4
  } reg_idx_e;

  typedef logic [MaxChannels-1:0][SampleBits-1:0] pix_t;

  // Settings the result side needs.
  typedef struct packed {
    logic [2:0]  nch;
    logic        wide;
    logic [10:0] coef;
  } back_cfg_t;

  // One queued pixel step with the results it causes.
  typedef struct packed {
    logic        e1;
    logic        e1_sharp;
    logic        e2;
    logic        e3;
    logic        done;
    logic [15:0] row;
    logic [AddrBits-1:0] col;
    logic [AddrBits-1:0] wlast;
    pix_t        held;
    logic [MaxChannels-1:0][SumBits-1:0] sum;
    pix_t        up1;
    pix_t        px;
  } job_t;

endpackage

// ===== hdl/hbs_front.sv =====
module hbs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hbs_pkg::pix_t     in_px_i,
  output logic              push_o,
  input  logic              full_i,
  output hbs_pkg::job_t     job_o,
  output hbs_pkg::back_cfg_t bcfg_o
);
  import hbs_pkg::*;

  logic [12:0] width_q;
  logic [15:0] height_q;
  logic [2:0]  nch_q;
  logic        depth_q;
  logic [6:0]  pct_q;

  logic [12:0] w_eff;
  logic [15:0] h_eff;
  logic [2:0]  nch_eff;
  logic [6:0]  pct_eff;
  logic [AddrBits-1:0] wlast;
  logic [15:0] hlast;
  logic        tiny_frame;

  logic [15:0] row_q, row_d, r_cur;
  logic [AddrBits-1:0] col_q, col_d, c_cur;
  pix_t        px;
  logic        in_acc;

  logic        s1_valid_q, s1_valid_d, s1_go;
  logic [15:0] s1_r_q;
  logic [AddrBits-1:0] s1_c_q;
  pix_t        s1_px_q;

  pix_t        old_mem [MaxWidth];
  pix_t        new_mem [MaxWidth];
  pix_t        rd_old_q, rd_new_q;
  pix_t        held_q;
  logic [MaxChannels-1:0][LaneBits-1:0] cs, cs1_q, cs2_q;
  logic        wr_en;

  // Configuration registers; the port is always ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 16'd480;
      nch_q    <= 3'd3;
      depth_q  <= 1'b0;
      pct_q    <= 7'd50;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:   width_q  <= cfg_data_i[12:0];
        REG_HEIGHT:  height_q <= cfg_data_i;
        REG_CHANNEL: nch_q    <= cfg_data_i[2:0];
        REG_DEPTH:   depth_q  <= cfg_data_i[0];
        REG_PERCENT: pct_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Settings held to their legal ranges.
  always_comb begin
    w_eff   = (width_q == 13'd0) ? 13'd1 :
              (width_q > 13'(MaxWidth)) ? 13'(MaxWidth) : width_q;
    h_eff   = (height_q == 16'd0) ? 16'd1 : height_q;
    nch_eff = (nch_q == 3'd0) ? 3'd1 :
              (nch_q > 3'(MaxChannels)) ? 3'(MaxChannels) : nch_q;
    pct_eff = (pct_q > 7'd100) ? 7'd100 : pct_q;
    wlast   = AddrBits'(w_eff - 13'd1);
    hlast   = h_eff - 16'd1;
    tiny_frame = (w_eff < 13'd3) || (h_eff < 16'd3);
  end

  assign bcfg_o.nch  = nch_eff;
  assign bcfg_o.wide = depth_q;
  assign bcfg_o.coef = 11'd450 + 11'(pct_eff) * 11'd9;

  // Position of the incoming pixel and its masked samples.
  always_comb begin
    r_cur = (row_q < h_eff) ? row_q : hlast;
    c_cur = ({1'b0, col_q} < w_eff) ? col_q : wlast;
    for (int ch = 0; ch < MaxChannels; ch++) begin
      if (3'(ch) < nch_eff) begin
        px[ch] = depth_q ? in_px_i[ch] : {8'd0, in_px_i[ch][7:0]};
      end else begin
        px[ch] = '0;
      end
    end
    if (c_cur >= wlast) begin
      col_d = '0;
      row_d = (r_cur >= hlast) ? 16'd0 : r_cur + 16'd1;
    end else begin
      col_d = c_cur + AddrBits'(1);
      row_d = r_cur;
    end
  end

  assign in_ready_o = !s1_valid_q || !full_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_go      = s1_valid_q && !full_i;
  assign s1_valid_d = in_acc || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_acc) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_r_q  <= r_cur;
      s1_c_q  <= c_cur;
      s1_px_q <= px;
    end
  end

  // Line buffers: read on accept, written when the step leaves stage one unless the frame is tiny.
  assign wr_en = s1_go && !tiny_frame;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      old_mem[s1_c_q] <= rd_new_q;
      new_mem[s1_c_q] <= s1_px_q;
    end
    if (in_acc) begin
      rd_old_q <= old_mem[c_cur];
      rd_new_q <= new_mem[c_cur];
    end
  end

  // Column sums of the window and the job handed to the queue.
  always_comb begin
    for (int ch = 0; ch < MaxChannels; ch++) begin
      cs[ch] = LaneBits'(rd_old_q[ch]) + LaneBits'(rd_new_q[ch])
             + LaneBits'(s1_px_q[ch]);
      job_o.sum[ch] = SumBits'(cs2_q[ch]) + SumBits'(cs1_q[ch])
                    + SumBits'(cs[ch]);
    end
    job_o.e1       = !tiny_frame && (s1_r_q != 16'd0) && (s1_c_q != '0);
    job_o.e1_sharp = (s1_r_q != 16'd1) && (s1_c_q != AddrBits'(1));
    job_o.e2       = !tiny_frame && (s1_r_q != 16'd0) && (s1_c_q == wlast);
    job_o.e3       = tiny_frame || (s1_r_q == hlast);
    job_o.done     = (s1_r_q == hlast) && (s1_c_q == wlast);
    job_o.row      = s1_r_q;
    job_o.col      = s1_c_q;
    job_o.wlast    = wlast;
    job_o.held     = held_q;
    job_o.up1      = rd_new_q;
    job_o.px       = s1_px_q;
  end

  assign push_o = s1_go && (job_o.e1 || job_o.e2 || job_o.e3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs1_q  <= '0;
      cs2_q  <= '0;
      held_q <= '0;
    end else if (wr_en) begin
      cs2_q  <= cs1_q;
      cs1_q  <= cs;
      held_q <= rd_new_q;
    end
  end

endmodule

// ===== hdl/hbs_fifo.sv =====
module hbs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hbs_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hbs_pkg::job_t data_o
);
  import hbs_pkg::*;

  job_t                 mem_q [FifoDepth];
  logic [FifoPtrBits-1:0] wr_q, rd_q;
  logic [FifoPtrBits:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (FifoPtrBits+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Occupancy follows each push and pop transaction.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FifoPtrBits+1)'(FifoDepth)) else $error("queue count overrun");

endmodule

// ===== hdl/hbs_back.sv =====
module hbs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbs_pkg::back_cfg_t bcfg_i,
  input  logic               head_valid_i,
  input  hbs_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        out_row_o,
  output logic [11:0]        out_col_o,
  output hbs_pkg::pix_t      out_px_o,
  output logic               out_done_o
);
  import hbs_pkg::*;

  typedef struct packed {
    logic        sharp;
    logic        done;
    logic [15:0] row;
    logic [AddrBits-1:0] col;
    pix_t        copy;
  } meta_t;

  logic        en;
  logic [2:0]  taken_q, taken_d, pend, pick;
  logic        issue;
  meta_t       m0;
  logic [MaxChannels-1:0][NumBits-1:0] num0;

  logic        st1_valid_q, st2_valid_q, out_valid_q;
  meta_t       st1_meta_q, st2_meta_q;
  logic [MaxChannels-1:0][NumBits-1:0] st1_num_q;
  logic [MaxChannels-1:0][NumBits+27:0] st2_prod_q;
  pix_t        res;

  logic [15:0] out_row_q;
  logic [AddrBits-1:0] out_col_q;
  pix_t        out_px_q;
  logic        out_done_q;

  // The whole result pipeline moves when the output register can take data.
  assign en = !out_valid_q || out_ready_i;

  // Pick the earliest result of the head job not yet issued.
  always_comb begin
    pend    = {head_i.e3, head_i.e2, head_i.e1} & ~taken_q;
    pick    = pend & (~pend + 3'd1);
    issue   = en && head_valid_i;
    pop_o   = issue && (pend == pick);
    taken_d = taken_q;
    if (issue) taken_d = pop_o ? 3'd0 : (taken_q | pick);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) taken_q <= '0;
    else         taken_q <= taken_d;
  end

  // Coordinates, copy values and sharpening numerators of the chosen result.
  always_comb begin
    logic signed [29:0] n;
    m0.sharp = 1'b0;
    m0.done  = 1'b0;
    m0.row   = head_i.row;
    m0.col   = head_i.col;
    m0.copy  = head_i.px;
    unique case (1'b1)
      pick[0]: begin
        m0.sharp = head_i.e1_sharp;
        m0.row   = head_i.row - 16'd1;
        m0.col   = head_i.col - AddrBits'(1);
        m0.copy  = head_i.held;
      end
      pick[1]: begin
        m0.row  = head_i.row - 16'd1;
        m0.col  = head_i.wlast;
        m0.copy = head_i.up1;
      end
      default: begin
        m0.done = head_i.done;
      end
    endcase
    for (int ch = 0; ch < MaxChannels; ch++) begin
      if (3'(ch) >= bcfg_i.nch) m0.copy[ch] = '0;
      n = $signed(30'(bcfg_i.coef) * 30'(head_i.held[ch]))
        - $signed(30'(head_i.sum[ch]) * 30'd50) + 30'sd225;
      num0[ch] = n[29] ? '0 : n[NumBits-1:0];
    end
  end

  // Stage one holds numerators, stage two the reciprocal products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q <= 1'b0;
      st2_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      st1_valid_q <= issue;
      st2_valid_q <= st1_valid_q;
      out_valid_q <= st2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_meta_q <= m0;
      st1_num_q  <= num0;
      st2_meta_q <= st1_meta_q;
      for (int ch = 0; ch < MaxChannels; ch++) begin
        st2_prod_q[ch] <= (NumBits+28)'(st1_num_q[ch]) * (NumBits+28)'(Recip450);
      end
      out_row_q  <= st2_meta_q.row;
      out_col_q  <= st2_meta_q.col;
      out_done_q <= st2_meta_q.done;
      out_px_q   <= res;
    end
  end

  // Quotient by 450 for sharpened results, clamp to the sample range, copies pass through, unused channels zero.
  always_comb begin
    logic [18:0] q;
    logic [18:0] maxv;
    maxv = bcfg_i.wide ? 19'd65535 : 19'd255;
    for (int ch = 0; ch < MaxChannels; ch++) begin
      q = st2_prod_q[ch][RecipShift +: 19];
      if (q > maxv) q = maxv;
      if (!st2_meta_q.sharp)             res[ch] = st2_meta_q.copy[ch];
      else if (3'(ch) >= bcfg_i.nch)     res[ch] = '0;
      else                               res[ch] = q[SampleBits-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_px_o    = out_px_q;
  assign out_done_o  = out_done_q;

  a_job_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (head_i.e1 || head_i.e2 || head_i.e3))
    else $error("queued step without results");
  a_taken_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (taken_q != 3'd0) |-> head_valid_i) else $error("partial job lost");
  a_taken_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(taken_q) <= 2) else $error("job issued past its end");

endmodule

// ===== hdl/high_boost_sharpen_3x3.sv =====
// An input pixel reaches the output register through the stage-one registers, the
// step queue and the numerator and product stages; extra results of a step follow it.
// Throughput: one pixel per cycle and one result per cycle, set by the single output
// register, while nothing stalls; steps with two or three results issue them in turn.
// Reset (rst_ni low, asynchronous) restores default settings and clears counters,
// column sums and queues; line buffer contents stay undefined until written.
module high_boost_sharpen_3x3 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_ch0, sample_ch1, sample_ch2, sample_ch3
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_row, out_col, out_ch0, out_ch1, out_ch2, out_ch3, zero fill
  output logic [95:0] m_axis_tdata,
  // frame_done
  output logic        m_axis_tlast
);
  import hbs_pkg::*;

  back_cfg_t bcfg;
  job_t      job, head;
  logic      push, full, head_valid, pop;
  logic [15:0] out_row;
  logic [11:0] out_col;
  pix_t      out_px;

  assign cfg_ready_o = 1'b1;

  // Front: settings, counters, line buffers and window sums.
  hbs_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_px_i    (s_axis_tdata),
    .push_o     (push),
    .full_i     (full),
    .job_o      (job),
    .bcfg_o     (bcfg)
  );

  // Queue of pixel steps between the two sides.
  hbs_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  // Back: result expansion, arithmetic and output register.
  hbs_back u_back (
    .clk_i, .rst_ni,
    .bcfg_i       (bcfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_px_o     (out_px),
    .out_done_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_px, out_col, out_row};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hbs_pkg::*;

  // A result pixel as it leaves the block.
  typedef struct packed {
    logic [15:0]      row;
    logic [11:0]      col;
    logic [3:0][15:0] ch;
    logic             done;
  } out_pix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // sample_ch0, sample_ch1, sample_ch2, sample_ch3
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // out_row, out_col, out_ch0, out_ch1, out_ch2, out_ch3, zero fill
  logic [95:0] m_axis_tdata;
  // frame_done
  logic        m_axis_tlast;

  high_boost_sharpen_3x3 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow settings and filter state of the sharpener.
  logic [12:0] sh_width  = 13'd640;
  logic [15:0] sh_height = 16'd480;
  logic [2:0]  sh_nch    = 3'd3;
  logic        sh_wide   = 1'b0;
  logic [6:0]  sh_pct    = 7'd50;
  logic [63:0] line_older [MaxWidth];
  logic [63:0] line_newer [MaxWidth];
  logic [3:0][17:0] csum_prev2 = '0;
  logic [3:0][17:0] csum_prev1 = '0;
  logic [63:0] center_held = '0;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  logic [63:0] pixel_q [$];
  out_pix_t    pixel_exp_q [$];
  logic        calm = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_off = 1'b0;
  logic        in_taken = 1'b0;
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;

  function automatic logic [15:0] lane_of(logic [63:0] v, int ch);
    return v[16*ch +: 16];
  endfunction

  function automatic logic [3:0][15:0] copy_lanes(logic [63:0] v, int unsigned nch);
    logic [3:0][15:0] o;
    for (int ch = 0; ch < 4; ch++) o[ch] = (ch < nch) ? lane_of(v, ch) : 16'd0;
    return o;
  endfunction

  // Work out the result pixels caused by one accepted input pixel.
  task automatic sharpen_step(logic [63:0] din);
    int unsigned w, h, nch, pct, maxv, r, c;
    logic [3:0][15:0] px, vals;
    logic [3:0][19:0] cs;
    logic [63:0] packed_px, up2, up1;
    longint num, q;
    int unsigned sum;
    w = sh_width;
    h = sh_height;
    nch = sh_nch;
    pct = sh_pct;
    maxv = sh_wide ? 65535 : 255;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    if (h < 1) h = 1;
    if (nch < 1) nch = 1;
    if (nch > 4) nch = 4;
    if (pct > 100) pct = 100;
    r = (row_pos < h) ? row_pos : h - 1;
    c = (col_pos < w) ? col_pos : w - 1;
    for (int ch = 0; ch < 4; ch++) px[ch] = (ch < nch) ? 16'(lane_of(din, ch) & maxv) : 16'd0;
    packed_px = px;
    if (w < 3 || h < 3) begin
      pixel_exp_q.push_back('{16'(r), 12'(c), px, (r == h - 1 && c == w - 1)});
    end else begin
      up2 = line_older[c];
      up1 = line_newer[c];
      for (int ch = 0; ch < 4; ch++) cs[ch] = lane_of(up2, ch) + lane_of(up1, ch) + px[ch];
      if (r >= 1 && c >= 1) begin
        if (r == 1 || c == 1) begin
          vals = copy_lanes(center_held, nch);
        end else begin
          for (int ch = 0; ch < 4; ch++) begin
            if (ch >= nch) begin
              vals[ch] = 0;
            end else begin
              sum = csum_prev2[ch] + csum_prev1[ch] + cs[ch];
              num = 64'sd9 * (50 + pct) * lane_of(center_held, ch) - 64'sd50 * sum + 225;
              q = (num < 0) ? 0 : num / 450;
              if (q > maxv) q = maxv;
              vals[ch] = q[15:0];
            end
          end
        end
        pixel_exp_q.push_back('{16'(r - 1), 12'(c - 1), vals, 1'b0});
      end
      if (r >= 1 && c == w - 1)
        pixel_exp_q.push_back('{16'(r - 1), 12'(w - 1), copy_lanes(up1, nch), 1'b0});
      if (r == h - 1) pixel_exp_q.push_back('{16'(r), 12'(c), px, (c == w - 1)});
      line_older[c] = up1;
      line_newer[c] = packed_px;
      for (int ch = 0; ch < 4; ch++) begin
        csum_prev2[ch] = csum_prev1[ch];
        csum_prev1[ch] = cs[ch][17:0];
      end
      center_held = up1;
    end
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // Source driver: present pixels from the pending queue with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (send_idle > 0) begin
        send_idle = send_idle - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_idle = $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        s_axis_tdata <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Every accepted input transaction updates the prediction.
  always @(posedge clk_i) begin
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_taken) sharpen_step(s_axis_tdata);
  end

  // Sink ready with random stall bursts and a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (recv_idle > 0) begin
      recv_idle = recv_idle - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_idle = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Long receiver stall, counted here, while the source keeps offering.
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  // Monitor: compare each output transaction with the oldest prediction.
  always @(posedge clk_i) begin
    out_pix_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row = m_axis_tdata[15:0];
      got.col = m_axis_tdata[27:16];
      for (int ch = 0; ch < 4; ch++) got.ch[ch] = m_axis_tdata[28 + 16*ch +: 16];
      got.done = m_axis_tlast;
      if (pixel_exp_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("Unexpected output pixel row %0d col %0d", got.row, got.col);
      end else begin
        want = pixel_exp_q.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.ch !== want.ch ||
            got.done !== want.done || m_axis_tdata[95:92] !== 4'd0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("Mismatch: expected r%0d c%0d ch %h done %0d, got r%0d c%0d ch %h done %0d",
                     want.row, want.col, want.ch, want.done,
                     got.row, got.col, got.ch, got.done);
        end
      end
    end
  end

  // Configuration write; the shadow settings follow the accepted transaction.
  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WIDTH:   sh_width = val[12:0];
      REG_HEIGHT:  sh_height = val;
      REG_CHANNEL: sh_nch = val[2:0];
      REG_DEPTH:   sh_wide = val[0];
      REG_PERCENT: sh_pct = val[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] w, logic [15:0] h, logic [15:0] n,
                         logic [15:0] d, logic [15:0] p);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_CHANNEL, n);
    write_reg(REG_DEPTH, d);
    write_reg(REG_PERCENT, p);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'h00FF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Queue one whole frame of pixels for the current settings.
  task automatic queue_frame();
    int unsigned w, h;
    w = (sh_width < 1) ? 1 : (sh_width > MaxWidth) ? MaxWidth : sh_width;
    h = (sh_height < 1) ? 1 : sh_height;
    repeat (w * h) pixel_q.push_back({rand_sample(), rand_sample(), rand_sample(), rand_sample()});
  endtask

  task automatic drain();
    wait (pixel_q.size() == 0 && !s_axis_tvalid && pixel_exp_q.size() == 0);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: saturation and clamp to zero with full strength, 16-bit, 4 channels.
    set_all(3, 3, 4, 1, 100);
    pixel_q.push_back('0);
    pixel_q.push_back('1);
    pixel_q.push_back('0);
    pixel_q.push_back('1);
    pixel_q.push_back(64'h0000_FFFF_0000_FFFF);
    pixel_q.push_back('1);
    pixel_q.push_back('0);
    pixel_q.push_back('1);
    pixel_q.push_back('0);
    drain();
    // Directed: 8-bit mode with oversized samples, one channel, no boost.
    set_all(4, 3, 1, 0, 0);
    repeat (12) pixel_q.push_back({rand_sample(), rand_sample(), rand_sample(), 16'hFFFF});
    drain();

    // Random frames, small ones included, out of range settings too.
    for (int k = 0; k < 2; k++) begin
      set_all(16'($urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 7)),
              16'($urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 5)),
              16'($urandom_range(0, 7)), 16'($urandom_range(0, 1)),
              16'($urandom_range(0, 127)));
      queue_frame();
      drain();
    end

    // Wider frame, with the receiver holding off to back up the pipeline.
    set_all(8, 3, 3, 1, 127);
    hold_go = 1'b1;
    queue_frame();
    drain();
    // A single column of copies, width clamped up from zero.
    set_all(0, 8, 2, 0, 50);
    queue_frame();
    drain();
    // A single row of copies.
    set_all(9, 1, 4, 1, 1);
    queue_frame();
    drain();

    // Last part without idling.
    calm = 1'b1;
    set_all(5, 4, 3, 0, 50);
    queue_frame();
    drain();
    repeat (30) @(negedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
